@@ hdl/bitmap_page_allocator_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Same-cycle and next-cycle implication checks, clocked on clk and
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bpa_pkg.sv @@
// ---------------------------------------------------------------------------
// bpa_pkg
// Types and codes shared by the bitmap page allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;
  localparam logic [1:0] STAT_ALREADY = 2'd3;

  localparam logic [10:0] ACTIVE_RST = 11'd1024;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_MARK = 6'b001000,
    ST_FCHK = 6'b010000,
    ST_RESP = 6'b100000
  } bpa_state_t;

endpackage

@@ hdl/bitmap_page_allocator_core.sv @@
// Allocator operation: after reset the map is filled with ones, one 32-bit
// word per cycle, over ceil(min(BLOCKS,2047)/32) words (32 at 1024 blocks);
// no request is taken meanwhile. A free reads its word, then ST_FCHK clears
// the bit if set and passes to ST_RESP. An allocate scans the map one word per
// cycle from word 0 until the run is found or the last word fails (NOSPACE),
// then rewrites every word the run touches (one read-modify-write per cycle
// on the map's single write port). A refused count of zero or an out-of-range
// free goes from ST_IDLE straight to ST_RESP as STAT_BAD. One request is in
// work at a time; the next may be taken while the previous result waits at the output.
// ---------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page allocator over a one-bit-per-block used map held in a
// synchronous memory, with a free block counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: active_blocks
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // run_length[9:0], block_index[19:10], zero pad
  input  logic        in_tuser,   // req_type
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], start_block[11:2], free_count[22:12], pad
);

  localparam int LIMIT_MAX = (BLOCKS < 2047) ? BLOCKS : 2047;
  localparam int MEM_WORDS = (LIMIT_MAX + 31) / 32;
  localparam int WA_W      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int BI_W      = WA_W + 5;
  localparam int LIM_W     = $clog2(LIMIT_MAX + 1);

  // map memory
  logic [31:0]     map_mem [MEM_WORDS];
  logic [31:0]     rd_data_r;
  logic            map_we, map_re;
  logic [WA_W-1:0] map_waddr, map_raddr;
  logic [31:0]     map_wdata;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) rd_data_r <= map_mem[map_raddr];
  end

  bpa_state_t       state_r, state_nxt;
  logic [10:0]      active_r;
  logic [LIM_W-1:0] limit_r, limit_nxt, lim_in;
  logic             typ_r, typ_nxt;
  logic [9:0]       len_r, len_nxt;
  logic [4:0]       fpos_r, fpos_nxt;
  logic [WA_W-1:0]  cur_r, cur_nxt;
  logic [WA_W-1:0]  wk_r, wk_nxt;
  logic [WA_W-1:0]  clr_r, clr_nxt;
  logic             pend_r, pend_nxt;
  logic [9:0]       run_r, run_nxt;
  logic [BI_W-1:0]  s_r, s_nxt, e_r, e_nxt;
  logic [10:0]      fc_r, fc_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [9:0]       res_start_r, res_start_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r;
  logic [9:0]       out_start_r;
  logic [10:0]      out_fc_r;
  logic             ld_out;

  logic [9:0]       in_len, in_idx;
  logic             in_acc;
  logic [WA_W-1:0]  last_word;

  assign in_len    = in_tdata[9:0];
  assign in_idx    = in_tdata[19:10];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign lim_in    = (active_r > 11'(LIMIT_MAX)) ? LIM_W'(LIMIT_MAX) : LIM_W'(active_r);
  assign last_word = (limit_r == '0) ? '0 : WA_W'((limit_r - 1'b1) >> 5);

  // word scan: effective used bits, nearest used bit at or below each place
  logic [31:0]      used_w;
  logic [BI_W-1:0]  gidx;
  logic             pf_has [6][32];
  logic [4:0]       pf_pos [6][32];
  logic [10:0]      run_p  [32];
  logic [31:0]      hit_v;
  logic             hit_any;
  logic [4:0]       hit_pos;
  logic [10:0]      run_end;
  logic [BI_W-1:0]  e_cmb, s_cmb;

  always_comb begin
    used_w = '0;
    gidx   = '0;
    for (int p = 0; p < 32; p++) begin
      gidx      = {cur_r, 5'(p)};
      used_w[p] = rd_data_r[p] || ({1'b0, gidx} >= (BI_W+1)'(limit_r)) || (gidx == '0);
    end
  end

  always_comb begin
    for (int p = 0; p < 32; p++) begin
      pf_has[0][p] = used_w[p];
      pf_pos[0][p] = 5'(p);
    end
    for (int k = 0; k < 5; k++) begin
      for (int p = 0; p < 32; p++) begin
        if (p >= (1 << k) && !pf_has[k][p]) begin
          pf_has[k+1][p] = pf_has[k][p - (1 << k)];
          pf_pos[k+1][p] = pf_pos[k][p - (1 << k)];
        end else begin
          pf_has[k+1][p] = pf_has[k][p];
          pf_pos[k+1][p] = pf_pos[k][p];
        end
      end
    end
  end

  always_comb begin
    hit_v   = '0;
    hit_pos = '0;
    for (int p = 0; p < 32; p++) begin
      run_p[p] = pf_has[5][p] ? (11'(p) - 11'(pf_pos[5][p])) : (11'(run_r) + 11'(p + 1));
      hit_v[p] = (run_p[p] >= {1'b0, len_r});
    end
    for (int p = 31; p >= 0; p--) begin
      if (hit_v[p]) hit_pos = 5'(p);
    end
    hit_any = |hit_v;
    run_end = pf_has[5][31] ? (11'd31 - 11'(pf_pos[5][31])) : (11'(run_r) + 11'd32);
    e_cmb   = {cur_r, hit_pos};
    s_cmb   = e_cmb - BI_W'(len_r) + 1'b1;
  end

  // run marking mask for the word in write-back
  logic [WA_W-1:0] ws_word, we_word;
  logic [4:0]      mk_lo, mk_hi;
  logic [31:0]     mark_mask;

  assign ws_word = s_r[BI_W-1:5];
  assign we_word = e_r[BI_W-1:5];
  assign mk_lo   = (wk_r == ws_word) ? s_r[4:0] : 5'd0;
  assign mk_hi   = (wk_r == we_word) ? e_r[4:0] : 5'd31;

  always_comb begin
    for (int p = 0; p < 32; p++) begin
      mark_mask[p] = (5'(p) >= mk_lo) && (5'(p) <= mk_hi);
    end
  end

  assign ld_out = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    typ_nxt        = typ_r;
    len_nxt        = len_r;
    fpos_nxt       = fpos_r;
    cur_nxt        = cur_r;
    wk_nxt         = wk_r;
    clr_nxt        = clr_r;
    pend_nxt       = pend_r;
    run_nxt        = run_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    fc_nxt         = fc_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    map_we         = 1'b0;
    map_re         = 1'b0;
    map_waddr      = wk_r;
    map_raddr      = cur_r;
    map_wdata      = rd_data_r | mark_mask;

    case (state_r)
      ST_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '1;
        if (clr_r == WA_W'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          typ_nxt       = in_tuser;
          len_nxt       = in_len;
          limit_nxt     = lim_in;
          fpos_nxt      = in_idx[4:0];
          res_start_nxt = '0;
          if (in_tuser == REQ_ALLOC) begin
            if (in_len == '0) begin
              res_status_nxt = STAT_BAD;
              state_nxt      = ST_RESP;
            end else begin
              map_re    = 1'b1;
              map_raddr = '0;
              cur_nxt   = '0;
              run_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end else begin
            if ({1'b0, in_idx} >= 11'(lim_in)) begin
              res_status_nxt = STAT_BAD;
              state_nxt      = ST_RESP;
            end else begin
              map_re    = 1'b1;
              map_raddr = WA_W'(in_idx[9:5]);
              cur_nxt   = WA_W'(in_idx[9:5]);
              state_nxt = ST_FCHK;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          s_nxt          = s_cmb;
          e_nxt          = e_cmb;
          fc_nxt         = (fc_r >= {1'b0, len_r}) ? (fc_r - {1'b0, len_r}) : '0;
          res_status_nxt = STAT_OK;
          res_start_nxt  = 10'(s_cmb);
          cur_nxt        = s_cmb[BI_W-1:5];
          pend_nxt       = 1'b0;
          state_nxt      = ST_MARK;
        end else if (cur_r == last_word) begin
          res_status_nxt = STAT_NOSPACE;
          state_nxt      = ST_RESP;
        end else begin
          map_re    = 1'b1;
          map_raddr = cur_r + 1'b1;
          cur_nxt   = cur_r + 1'b1;
          run_nxt   = 10'(run_end);
        end
      end
      ST_MARK: begin
        // write back word wk_r while reading the next one
        map_we    = pend_r;
        map_re    = (cur_r <= we_word) && !(pend_r && (wk_r == we_word));
        map_raddr = cur_r;
        pend_nxt  = map_re;
        wk_nxt    = cur_r;
        cur_nxt   = cur_r + 1'b1;
        if (pend_r && (wk_r == we_word)) begin
          state_nxt = ST_RESP;
        end
      end
      ST_FCHK: begin
        if (rd_data_r[fpos_r]) begin
          map_we         = 1'b1;
          map_waddr      = cur_r;
          map_wdata      = rd_data_r & ~(32'd1 << fpos_r);
          fc_nxt         = fc_r + 1'b1;
          res_status_nxt = STAT_OK;
        end else begin
          res_status_nxt = STAT_ALREADY;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (ld_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      active_r    <= ACTIVE_RST;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r      <= limit_nxt;
    typ_r        <= typ_nxt;
    len_r        <= len_nxt;
    fpos_r       <= fpos_nxt;
    cur_r        <= cur_nxt;
    wk_r         <= wk_nxt;
    run_r        <= run_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    if (ld_out) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_fc_r     <= fc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_fc_r, out_start_r, out_status_r};

  logic alloc_ok_ld;

  assign alloc_ok_ld = ld_out && (res_status_r == STAT_OK) && (typ_r == REQ_ALLOC);

  `include "bitmap_page_allocator_core_assert.svh"

  `BPA_ASSERT_IMP(a_no_block_zero, alloc_ok_ld, res_start_r != '0, "block zero allocated")
  `BPA_ASSERT_IMP(a_no_rw_collide, map_we && map_re, map_waddr != map_raddr, "map port clash")
  `BPA_ASSERT_IMP(a_run_below_len, state_r == ST_SCAN, run_r < len_r, "scan run overran")
  `BPA_ASSERT_NXT(a_one_in_work, in_acc, !in_tready, "second request taken")

endmodule
